### design/tos_pkg.sv
// ============================================================================
// tos_pkg
// Shared types and codes for the typed operand stack: command and status
// codes, type tags, the stored entry and the shift control for the cell chain.
// ============================================================================
`default_nettype none

package tos_pkg;

    // Storage depth defaults and fixed field widths
    localparam int STACK_DEPTH_DEF = 32;
    localparam int CAP_W           = 6;
    localparam int DEPTH_W         = 6;
    localparam int VALUE_W         = 64;
    localparam int TAG_W           = 3;
    localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

    // Type tags
    localparam logic [TAG_W-1:0] TAG_NONE   = 3'd0;
    localparam logic [TAG_W-1:0] TAG_INT    = 3'd1;
    localparam logic [TAG_W-1:0] TAG_OBJECT = 3'd5;

    typedef enum logic [2:0] {
        CMD_PUSH        = 3'd0,
        CMD_POP_CHECKED = 3'd1,
        CMD_POP_ANY     = 3'd2,
        CMD_DUP         = 3'd3,
        CMD_PEEK        = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_MISMATCH  = 2'd3
    } status_t;

    // One stack entry
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [TAG_W-1:0]   tag;
    } entry_t;

    // Shift control broadcast to every cell
    typedef struct packed {
        logic push;   // every cell takes its upper neighbor
        logic pop;    // every cell takes its lower neighbor
    } shift_ctrl_t;

endpackage

`default_nettype wire

### design/tos_cell.sv
// ============================================================================
// tos_cell
// One stack slot. On push it takes the entry from the slot above it, on pop
// the entry from the slot below it, and otherwise it holds.
// ============================================================================
`default_nettype none

module tos_cell (
    input  wire                        aclk,
    input  wire tos_pkg::shift_ctrl_t  ctrl,
    input  wire tos_pkg::entry_t       from_above,
    input  wire tos_pkg::entry_t       from_below,
    output tos_pkg::entry_t            entry
);
    import tos_pkg::*;

    entry_t entry_reg;

    // Slot storage, payload only
    always_ff @(posedge aclk) begin
        if (ctrl.push) begin
            entry_reg <= from_above;
        end else if (ctrl.pop) begin
            entry_reg <= from_below;
        end
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

### design/tos_ctrl.sv
// ============================================================================
// tos_ctrl
// Command decode, depth counter and result register. Drives the shift control
// and the entry fed into the top cell; reads the top cell for pops, peeks and dups.
// ============================================================================
`default_nettype none

module tos_ctrl #(
    parameter int STACK_DEPTH = tos_pkg::STACK_DEPTH_DEF
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire  [tos_pkg::CAP_W-1:0]    capacity_limit,
    // command side
    input  wire                          in_valid,
    output logic                         in_ready,
    input  wire  [2:0]                   in_cmd,
    input  wire  [tos_pkg::TAG_W-1:0]    in_tag,
    input  wire  [tos_pkg::VALUE_W-1:0]  in_value,
    // cell chain
    input  wire tos_pkg::entry_t         top_entry,
    output tos_pkg::shift_ctrl_t         shift,
    output tos_pkg::entry_t              new_entry,
    // result side
    output logic                         out_valid,
    input  wire                          out_ready,
    output logic [tos_pkg::VALUE_W-1:0]  out_value,
    output logic [tos_pkg::TAG_W-1:0]    out_tag,
    output logic [1:0]                   out_status,
    output logic [tos_pkg::DEPTH_W-1:0]  out_depth
);
    import tos_pkg::*;

    // Depth never exceeds the 6-bit limit or the storage
    localparam int LimitCap = (STACK_DEPTH < 63) ? STACK_DEPTH : 63;

    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic               valid_reg;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic [TAG_W-1:0]   tag_reg, tag_next;
    status_t            status_reg, status_next;

    logic [DEPTH_W-1:0] lim;
    logic               fire, empty, full, tag_ok;

    assign in_ready = !valid_reg || out_ready;
    assign fire     = in_valid && in_ready;

    // Effective limit and stack conditions
    assign lim    = (int'(capacity_limit) > LimitCap) ? DEPTH_W'(LimitCap) : capacity_limit;
    assign empty  = (depth_reg == '0);
    assign full   = (depth_reg >= lim);
    assign tag_ok = (in_tag >= TAG_INT) && (in_tag <= TAG_OBJECT);

    // Command decode
    always_comb begin
        shift       = '0;
        new_entry   = '{value: in_value, tag: in_tag};
        depth_next  = depth_reg;
        value_next  = '0;
        tag_next    = TAG_NONE;
        status_next = ST_OK;
        case (cmd_t'(in_cmd))
            CMD_PUSH: begin
                if (!tag_ok) begin
                    status_next = ST_MISMATCH;
                end else if (full) begin
                    status_next = ST_OVERFLOW;
                end else begin
                    shift.push = 1'b1;
                    depth_next = depth_reg + 1'b1;
                end
            end
            CMD_POP_CHECKED, CMD_POP_ANY: begin
                if (empty) begin
                    status_next = ST_UNDERFLOW;
                end else begin
                    shift.pop  = 1'b1;
                    depth_next = depth_reg - 1'b1;
                    value_next = top_entry.value;
                    tag_next   = top_entry.tag;
                    if (cmd_t'(in_cmd) == CMD_POP_CHECKED && top_entry.tag != in_tag) begin
                        status_next = ST_MISMATCH;
                    end
                end
            end
            CMD_DUP: begin
                new_entry = top_entry;
                if (empty) begin
                    status_next = ST_UNDERFLOW;
                end else if (full) begin
                    status_next = ST_OVERFLOW;
                end else begin
                    shift.push = 1'b1;
                    depth_next = depth_reg + 1'b1;
                end
            end
            CMD_PEEK: begin
                if (!empty) begin
                    value_next = top_entry.value;
                    tag_next   = top_entry.tag;
                end
            end
            default: begin
            end
        endcase
        // Only an accepted item moves the chain
        if (!fire) begin
            shift = '0;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (fire) begin
                depth_reg <= depth_next;
                valid_reg <= 1'b1;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (fire) begin
            value_reg  <= value_next;
            tag_reg    <= tag_next;
            status_reg <= status_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_value  = value_reg;
    assign out_tag    = tag_reg;
    assign out_status = status_reg;
    assign out_depth  = depth_reg;

endmodule

`default_nettype wire

### design/typed_operand_stack_unit.sv
// ============================================================================
// typed_operand_stack_unit
// Operand stack of tagged 64-bit entries built as a chain of shifting cells,
// with the top of stack always in the first cell.
// ============================================================================
//
//  channel   dir   ports       contents
//  -------   ---   ---------   ---------------------------------------------
//  s_        in    tdata/tuser command, type tag, push value
//  m_        out   tdata/tuser result value, depth, result type, status
//  apb       in    p*          capacity_limit at address 0
//
//  One item per cycle while m_ does not stall: the whole chain shifts in
//  the cycle an item is accepted, since every command touches only the top cell.
//  The result sits in an output register in the cycle after acceptance; a new
//  item is taken in the same cycle that result is taken.
//  A stall on m_ holds the result and drops s_tready.
//  Reset clears the depth and sets capacity_limit to 32; cells hold no reset.
//
`default_nettype none

module typed_operand_stack_unit #(
    parameter int STACK_DEPTH = tos_pkg::STACK_DEPTH_DEF
) (
    input  wire         aclk,
    input  wire         aresetn,
    // input items
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [63:0] s_tdata,   // [63:0] push_value
    input  wire  [7:0]  s_tuser,   // [2:0] command, [5:3] type_tag, [7:6] zero
    // result items
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [71:0] m_tdata,   // [63:0] result_value, [69:64] depth_after, [71:70] zero
    output logic [7:0]  m_tuser,   // [2:0] result_type, [4:3] status, [7:5] zero
    // configuration
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tos_pkg::*;

    localparam int LimitCap  = (STACK_DEPTH < 63) ? STACK_DEPTH : 63;
    localparam int CellCount = LimitCap;

    logic [CAP_W-1:0]   cap_reg;
    entry_t             entries [CellCount];
    entry_t             new_entry;
    shift_ctrl_t        shift;
    logic [VALUE_W-1:0] res_value;
    logic [TAG_W-1:0]   res_tag;
    logic [1:0]         res_status;
    logic [DEPTH_W-1:0] res_depth;

    // Configuration register
    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
            cap_reg <= pwdata[CAP_W-1:0];
        end
    end
    assign prdata = (paddr[2] == 1'b0) ? {{(32-CAP_W){1'b0}}, cap_reg} : 32'd0;

    // Command decode and result register
    tos_ctrl #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .capacity_limit (cap_reg),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .in_cmd         (s_tuser[2:0]),
        .in_tag         (s_tuser[5:3]),
        .in_value       (s_tdata),
        .top_entry      (entries[0]),
        .shift          (shift),
        .new_entry      (new_entry),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_value      (res_value),
        .out_tag        (res_tag),
        .out_status     (res_status),
        .out_depth      (res_depth)
    );

    // Cell chain, top of stack in cell 0
    for (genvar i = 0; i < CellCount; i++) begin : g_cell
        entry_t above, below;
        if (i == 0) begin : g_top
            assign above = new_entry;
        end else begin : g_mid
            assign above = entries[i-1];
        end
        if (i == CellCount - 1) begin : g_bottom
            assign below = '0;
        end else begin : g_inner
            assign below = entries[i+1];
        end
        tos_cell u_cell (
            .aclk       (aclk),
            .ctrl       (shift),
            .from_above (above),
            .from_below (below),
            .entry      (entries[i])
        );
    end

    // Result packing
    assign m_tdata = {2'b00, res_depth, res_value};
    assign m_tuser = {3'b000, res_status, res_tag};

endmodule

`default_nettype wire
